// ----- hw/rtl/ssm_pkg.sv -----
// Shared types, constants and the microcode program of the servo pulse smoother.
package ssm_pkg;

    // Fixed-point format of the filtered position and the deadzone around the target.
    localparam int FRAC_BITS  = 8;
    localparam int DEADZONE   = 10;
    localparam int PULSE_W    = 12;
    localparam int FILT_W     = PULSE_W + FRAC_BITS;
    // The filter gain is Q1.8, so the product is always scaled back by eight bits.
    localparam int GAIN_W     = 9;
    localparam int GAIN_SHIFT = 8;
    localparam int GAIN_ONE   = 256;
    // The product register holds the filter product, which is the wider of the two uses.
    localparam int PROD_W     = FILT_W + 1 + GAIN_W + 1;
    // Degree mapping: angle times span magnitude, divided by max_angle one bit a step.
    localparam int ANGLE_W    = 9;
    localparam int QUOT_W     = ANGLE_W + PULSE_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // Operation codes of an input request.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_TGT_US  = 3'd1;
    localparam logic [2:0] OP_TGT_DEG = 3'd2;
    localparam logic [2:0] OP_CUR_US  = 3'd3;
    localparam logic [2:0] OP_CUR_DEG = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [2:0] REG_GAIN        = 3'd1;
    localparam logic [2:0] REG_MIN_PULSE   = 3'd2;
    localparam logic [2:0] REG_MAX_PULSE   = 3'd3;
    localparam logic [2:0] REG_MAX_ANGLE   = 3'd4;
    localparam logic [2:0] REG_AUTO_DETACH = 3'd5;
    localparam logic [2:0] REG_REVERSE     = 3'd6;
    localparam logic [2:0] REG_ENABLED     = 3'd7;

    // Datapath actions, one per control word.
    typedef enum logic [3:0] {
        UOP_NOP      = 4'd0,
        UOP_SET_TGT  = 4'd1,
        UOP_SET_CUR  = 4'd2,
        UOP_STEP     = 4'd3,
        UOP_MUL      = 4'd4,
        UOP_ACCUM    = 4'd5,
        UOP_CLAMP    = 4'd6,
        UOP_DEADZONE = 4'd7,
        UOP_DEG_MUL  = 4'd8,
        UOP_DEG_ABS  = 4'd9,
        UOP_DIV_STEP = 4'd10,
        UOP_DEG_DONE = 4'd11,
        UOP_FINISH   = 4'd12
    } uop_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        COND_NEVER     = 4'd0,
        COND_ALWAYS    = 4'd1,
        COND_OP_TICK   = 4'd2,
        COND_OP_TGT_US = 4'd3,
        COND_OP_CUR_US = 4'd4,
        COND_OP_DEG    = 4'd5,
        COND_NO_MOVE   = 4'd6,
        COND_DIV_BUSY  = 4'd7,
        COND_OUT_STALL = 4'd8
    } cond_t;

    localparam int PC_W = 5;

    typedef struct packed {
        uop_t            uop;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            last;
    } ctrl_word_t;

    // Program labels.
    localparam logic [PC_W-1:0] L_DISPATCH = 5'd0;
    localparam logic [PC_W-1:0] L_TGT      = 5'd5;
    localparam logic [PC_W-1:0] L_CUR      = 5'd6;
    localparam logic [PC_W-1:0] L_TICK     = 5'd7;
    localparam logic [PC_W-1:0] L_DZ       = 5'd12;
    localparam logic [PC_W-1:0] L_DEG      = 5'd13;
    localparam logic [PC_W-1:0] L_DIV      = 5'd15;
    localparam logic [PC_W-1:0] L_FIN      = 5'd17;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{uop: UOP_NOP, cond: COND_NEVER, target: L_DISPATCH, last: 1'b0};
        case (pc)
            5'd0:  w = '{uop: UOP_NOP,      cond: COND_OP_TICK,   target: L_TICK, last: 1'b0};
            5'd1:  w = '{uop: UOP_NOP,      cond: COND_OP_TGT_US, target: L_TGT,  last: 1'b0};
            5'd2:  w = '{uop: UOP_NOP,      cond: COND_OP_CUR_US, target: L_CUR,  last: 1'b0};
            5'd3:  w = '{uop: UOP_NOP,      cond: COND_OP_DEG,    target: L_DEG,  last: 1'b0};
            5'd4:  w = '{uop: UOP_NOP,      cond: COND_ALWAYS,    target: L_FIN,  last: 1'b0};
            5'd5:  w = '{uop: UOP_SET_TGT,  cond: COND_ALWAYS,    target: L_FIN,  last: 1'b0};
            5'd6:  w = '{uop: UOP_SET_CUR,  cond: COND_ALWAYS,    target: L_FIN,  last: 1'b0};
            5'd7:  w = '{uop: UOP_NOP,      cond: COND_NO_MOVE,   target: L_DZ,   last: 1'b0};
            5'd8:  w = '{uop: UOP_STEP,     cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd9:  w = '{uop: UOP_MUL,      cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd10: w = '{uop: UOP_ACCUM,    cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd11: w = '{uop: UOP_CLAMP,    cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd12: w = '{uop: UOP_DEADZONE, cond: COND_ALWAYS,    target: L_FIN,  last: 1'b0};
            5'd13: w = '{uop: UOP_DEG_MUL,  cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd14: w = '{uop: UOP_DEG_ABS,  cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd15: w = '{uop: UOP_DIV_STEP, cond: COND_DIV_BUSY,  target: L_DIV,  last: 1'b0};
            5'd16: w = '{uop: UOP_DEG_DONE, cond: COND_NEVER,     target: L_FIN,  last: 1'b0};
            5'd17: w = '{uop: UOP_FINISH,   cond: COND_OUT_STALL, target: L_FIN,  last: 1'b1};
            default: w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: L_FIN, last: 1'b0};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/servo_pulse_smoother.sv -----
// Servo pulse smoother: microcoded slew limiter and first-order filter for a servo pulse.
// After dispatch, a tick runs step, multiply, accumulate, clamp and deadzone, or only
// deadzone when it does not move; a set in us writes the target or current position, an
// unknown operation goes straight to finish, and a degree operation uses the bit-serial
// divider. One request is in work at a time; in_ready rises in the same cycle as out_valid.
// Reset clears the sequencer and output valid, and loads the register and state defaults.
module servo_pulse_smoother (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // Request channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [11:0] value,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pulse_width,
    output logic        pulse_written,
    output logic        drive_attached,
    output logic        arrived,
    output logic [11:0] position,
    output logic [11:0] target
);

    localparam int PW = ssm_pkg::PULSE_W;
    localparam int FW = ssm_pkg::FILT_W;
    localparam int FB = ssm_pkg::FRAC_BITS;
    localparam int PRW = ssm_pkg::PROD_W;
    localparam int QW = ssm_pkg::QUOT_W;
    localparam int AW = ssm_pkg::ANGLE_W;
    localparam int CW = ssm_pkg::DIV_CNT_W;

    // Configuration registers.
    logic [11:0]   max_speed_reg, max_speed_next;
    logic [8:0]    gain_reg, gain_next;
    logic [11:0]   min_pulse_reg, min_pulse_next;
    logic [11:0]   max_pulse_reg, max_pulse_next;
    logic [8:0]    max_angle_reg, max_angle_next;
    logic          auto_detach_reg, auto_detach_next;
    logic          reverse_reg, reverse_next;
    logic          enabled_reg, enabled_next;

    // Servo state.
    logic [PW-1:0] target_reg, target_next;
    logic [PW-1:0] stepped_reg, stepped_next;
    logic [FW-1:0] filtered_reg, filtered_next;
    logic          attached_reg, attached_next;

    // Sequencer.
    logic                     busy_reg, busy_next;
    logic [ssm_pkg::PC_W-1:0] pc_reg, pc_next;
    ssm_pkg::ctrl_word_t      ctrl;
    logic                     jump;

    // Request being worked on and the per-request result flags.
    logic [2:0]    op_reg, op_next;
    logic [11:0]   val_reg, val_next;
    logic [PW-1:0] pulse_work_reg, pulse_work_next;
    logic          written_work_reg, written_work_next;
    logic          arrived_work_reg, arrived_work_next;

    // Shared product register and the divider.
    logic signed [PRW-1:0] prod_reg, prod_next;
    logic [QW-1:0]         dq_reg, dq_next;
    logic [AW-1:0]         rem_reg, rem_next;
    logic                  deg_neg_reg, deg_neg_next;
    logic [CW-1:0]         div_cnt_reg, div_cnt_next;

    // Output register.
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_pulse_reg, out_pulse_next;
    logic          out_written_reg, out_written_next;
    logic          out_attached_reg, out_attached_next;
    logic          out_arrived_reg, out_arrived_next;
    logic [PW-1:0] out_position_reg, out_position_next;
    logic [PW-1:0] out_target_reg, out_target_next;

    logic in_accept;
    logic out_stall;

    // Slew step toward the target.
    logic        [8:0]  gain_clamped;
    logic signed [12:0] step_diff;
    logic signed [12:0] step_lim;
    logic signed [12:0] step_clamped;
    logic        [12:0] step_sum;

    // Filter: product, scaled correction and clamp.
    logic signed [FW:0]    filt_delta;
    logic signed [PRW-1:0] filt_prod;
    logic                  prod_neg;
    logic        [PRW-1:0] prod_mag;
    logic        [PRW-1:0] accum_shift;
    logic        [PRW-1:0] accum_adj;
    logic        [PRW-1:0] accum_sum;
    logic        [FW-1:0]  clamp_lo;
    logic        [FW-1:0]  clamp_hi;
    logic        [FW-1:0]  clamp_val;
    logic        [PW-1:0]  clamp_ipart;
    logic        [PW-1:0]  clamp_pulse;

    // Deadzone test.
    logic        [PW-1:0] dz_ipart;
    logic signed [12:0]   dz_diff;
    logic        [12:0]   dz_abs;
    logic                 dz_near;

    // Degree mapping.
    logic        [AW-1:0]  deg_clamped;
    logic signed [12:0]    deg_span;
    logic signed [PRW-1:0] deg_prod;
    logic        [AW:0]    div_shift;
    logic                  div_fits;
    logic        [AW:0]    div_sub;
    logic        [QW:0]    deg_q_signed;
    logic        [QW:0]    deg_sum;
    logic        [PW-1:0]  deg_result;

    assign in_ready  = !busy_reg;
    assign in_accept = in_valid && in_ready;
    assign out_stall = out_valid_reg && !out_ready;

    assign ctrl = ssm_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            ssm_pkg::COND_NEVER:     jump = 1'b0;
            ssm_pkg::COND_ALWAYS:    jump = 1'b1;
            ssm_pkg::COND_OP_TICK:   jump = (op_reg == ssm_pkg::OP_TICK);
            ssm_pkg::COND_OP_TGT_US: jump = (op_reg == ssm_pkg::OP_TGT_US);
            ssm_pkg::COND_OP_CUR_US: jump = (op_reg == ssm_pkg::OP_CUR_US);
            ssm_pkg::COND_OP_DEG:
                jump = op_reg inside {ssm_pkg::OP_TGT_DEG, ssm_pkg::OP_CUR_DEG};
            ssm_pkg::COND_NO_MOVE:   jump = !(enabled_reg && attached_reg);
            ssm_pkg::COND_DIV_BUSY:  jump = (div_cnt_reg != CW'(1));
            ssm_pkg::COND_OUT_STALL: jump = out_stall;
            default:                 jump = 1'b0;
        endcase
    end

    // The step toward the target is limited to max_speed in either direction.
    assign gain_clamped = (gain_reg > 9'(ssm_pkg::GAIN_ONE)) ? 9'(ssm_pkg::GAIN_ONE) : gain_reg;
    assign step_diff    = $signed({1'b0, target_reg}) - $signed({1'b0, stepped_reg});
    assign step_lim     = $signed({1'b0, max_speed_reg});
    always_comb
    begin
        if (step_diff > step_lim)
        begin
            step_clamped = step_lim;
        end
        else if (step_diff < -step_lim)
        begin
            step_clamped = -step_lim;
        end
        else
        begin
            step_clamped = step_diff;
        end
    end
    assign step_sum = {1'b0, stepped_reg} + $unsigned(step_clamped);

    // The correction truncates toward zero, so the magnitude is shifted and the sign put back.
    assign filt_delta  = $signed({1'b0, stepped_reg, {FB{1'b0}}}) - $signed({1'b0, filtered_reg});
    assign filt_prod   = filt_delta * $signed({1'b0, gain_clamped});
    assign prod_neg    = prod_reg[PRW-1];
    assign prod_mag    = prod_neg ? $unsigned(-prod_reg) : $unsigned(prod_reg);
    assign accum_shift = prod_mag >> ssm_pkg::GAIN_SHIFT;
    assign accum_adj   = prod_neg ? (~accum_shift + PRW'(1)) : accum_shift;
    // The filtered value always lands between its old value and the stepped position.
    assign accum_sum   = {{(PRW-FW){1'b0}}, filtered_reg} + accum_adj;

    // With crossed limits the lower bound wins only for values below it.
    assign clamp_lo = {min_pulse_reg, {FB{1'b0}}};
    assign clamp_hi = {max_pulse_reg, {FB{1'b0}}};
    always_comb
    begin
        if (filtered_reg < clamp_lo)
        begin
            clamp_val = clamp_lo;
        end
        else if (filtered_reg > clamp_hi)
        begin
            clamp_val = clamp_hi;
        end
        else
        begin
            clamp_val = filtered_reg;
        end
    end
    assign clamp_ipart = clamp_val[FW-1:FB];
    assign clamp_pulse = reverse_reg ? (max_pulse_reg - clamp_ipart) : clamp_ipart;

    assign dz_ipart = filtered_reg[FW-1:FB];
    assign dz_diff  = $signed({1'b0, target_reg}) - $signed({1'b0, dz_ipart});
    assign dz_abs   = dz_diff[12] ? $unsigned(-dz_diff) : $unsigned(dz_diff);
    assign dz_near  = (dz_abs < 13'(ssm_pkg::DEADZONE));

    // Degree mapping: angle times span over max_angle, the quotient truncated toward zero.
    assign deg_clamped = (val_reg > {3'b000, max_angle_reg}) ? max_angle_reg
                                                             : val_reg[AW-1:0];
    assign deg_span    = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});
    assign deg_prod    = $signed({1'b0, deg_clamped}) * deg_span;

    assign div_shift    = {rem_reg, dq_reg[QW-1]};
    assign div_fits     = (div_shift >= {1'b0, max_angle_reg});
    assign div_sub      = div_shift - {1'b0, max_angle_reg};
    assign deg_q_signed = deg_neg_reg ? (~{1'b0, dq_reg} + (QW+1)'(1)) : {1'b0, dq_reg};
    assign deg_sum      = deg_q_signed + {{(QW+1-PW){1'b0}}, min_pulse_reg};
    // A zero max_angle maps every angle to min_pulse.
    assign deg_result   = (max_angle_reg == 9'd0) ? min_pulse_reg : deg_sum[PW-1:0];

    always_comb
    begin
        max_speed_next    = max_speed_reg;
        gain_next         = gain_reg;
        min_pulse_next    = min_pulse_reg;
        max_pulse_next    = max_pulse_reg;
        max_angle_next    = max_angle_reg;
        auto_detach_next  = auto_detach_reg;
        reverse_next      = reverse_reg;
        enabled_next      = enabled_reg;
        target_next       = target_reg;
        stepped_next      = stepped_reg;
        filtered_next     = filtered_reg;
        attached_next     = attached_reg;
        busy_next         = busy_reg;
        pc_next           = pc_reg;
        op_next           = op_reg;
        val_next          = val_reg;
        pulse_work_next   = pulse_work_reg;
        written_work_next = written_work_reg;
        arrived_work_next = arrived_work_reg;
        prod_next         = prod_reg;
        dq_next           = dq_reg;
        rem_next          = rem_reg;
        deg_neg_next      = deg_neg_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg;
        out_pulse_next    = out_pulse_reg;
        out_written_next  = out_written_reg;
        out_attached_next = out_attached_reg;
        out_arrived_next  = out_arrived_reg;
        out_position_next = out_position_reg;
        out_target_next   = out_target_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                ssm_pkg::REG_MAX_SPEED:   max_speed_next   = cfg_data;
                ssm_pkg::REG_GAIN:        gain_next        = cfg_data[8:0];
                ssm_pkg::REG_MIN_PULSE:   min_pulse_next   = cfg_data;
                ssm_pkg::REG_MAX_PULSE:   max_pulse_next   = cfg_data;
                ssm_pkg::REG_MAX_ANGLE:   max_angle_next   = cfg_data[8:0];
                ssm_pkg::REG_AUTO_DETACH: auto_detach_next = cfg_data[0];
                ssm_pkg::REG_REVERSE:     reverse_next     = cfg_data[0];
                ssm_pkg::REG_ENABLED:     enabled_next     = cfg_data[0];
                default:                  max_speed_next   = max_speed_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            // A new request starts the program with its result flags cleared.
            op_next           = operation;
            val_next          = value;
            pulse_work_next   = '0;
            written_work_next = 1'b0;
            arrived_work_next = 1'b0;
            busy_next         = 1'b1;
            pc_next           = ssm_pkg::L_DISPATCH;
        end
        else if (busy_reg)
        begin
            case (ctrl.uop)
                ssm_pkg::UOP_NOP:
                begin
                    pc_next = pc_reg;
                end
                ssm_pkg::UOP_SET_TGT:
                begin
                    target_next = val_reg;
                end
                ssm_pkg::UOP_SET_CUR:
                begin
                    stepped_next  = val_reg;
                    filtered_next = {val_reg, {FB{1'b0}}};
                end
                ssm_pkg::UOP_STEP:
                begin
                    stepped_next = step_sum[PW-1:0];
                end
                ssm_pkg::UOP_MUL:
                begin
                    prod_next = filt_prod;
                end
                ssm_pkg::UOP_ACCUM:
                begin
                    filtered_next = accum_sum[FW-1:0];
                end
                ssm_pkg::UOP_CLAMP:
                begin
                    filtered_next     = clamp_val;
                    pulse_work_next   = clamp_pulse;
                    written_work_next = 1'b1;
                end
                ssm_pkg::UOP_DEADZONE:
                begin
                    if (dz_near)
                    begin
                        if (auto_detach_reg && attached_reg)
                        begin
                            stepped_next  = target_reg;
                            attached_next = 1'b0;
                        end
                        arrived_work_next = !(attached_reg && !auto_detach_reg);
                    end
                    else
                    begin
                        if (auto_detach_reg && !attached_reg)
                        begin
                            attached_next = 1'b1;
                        end
                        arrived_work_next = 1'b0;
                    end
                end
                ssm_pkg::UOP_DEG_MUL:
                begin
                    prod_next = deg_prod;
                end
                ssm_pkg::UOP_DEG_ABS:
                begin
                    dq_next      = prod_mag[QW-1:0];
                    deg_neg_next = prod_neg;
                    rem_next     = '0;
                    div_cnt_next = CW'(ssm_pkg::DIV_STEPS);
                end
                ssm_pkg::UOP_DIV_STEP:
                begin
                    rem_next     = div_fits ? div_sub[AW-1:0] : div_shift[AW-1:0];
                    dq_next      = {dq_reg[QW-2:0], div_fits};
                    div_cnt_next = div_cnt_reg - CW'(1);
                end
                ssm_pkg::UOP_DEG_DONE:
                begin
                    if (op_reg == ssm_pkg::OP_TGT_DEG)
                    begin
                        target_next = deg_result;
                    end
                    else
                    begin
                        stepped_next  = deg_result;
                        filtered_next = {deg_result, {FB{1'b0}}};
                    end
                end
                ssm_pkg::UOP_FINISH:
                begin
                    if (!out_stall)
                    begin
                        out_valid_next    = 1'b1;
                        out_pulse_next    = pulse_work_reg;
                        out_written_next  = written_work_reg;
                        out_attached_next = attached_reg;
                        out_arrived_next  = arrived_work_reg;
                        out_position_next = filtered_reg[FW-1:FB];
                        out_target_next   = target_reg;
                    end
                end
                default:
                begin
                    pc_next = pc_reg;
                end
            endcase

            if (jump)
            begin
                pc_next = ctrl.target;
            end
            else if (ctrl.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + ssm_pkg::PC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg   <= 12'd100;
            gain_reg        <= 9'd64;
            min_pulse_reg   <= 12'd500;
            max_pulse_reg   <= 12'd2500;
            max_angle_reg   <= 9'd180;
            auto_detach_reg <= 1'b0;
            reverse_reg     <= 1'b0;
            enabled_reg     <= 1'b1;
            target_reg      <= '0;
            stepped_reg     <= '0;
            filtered_reg    <= '0;
            attached_reg    <= 1'b1;
            busy_reg        <= 1'b0;
            pc_reg          <= ssm_pkg::L_DISPATCH;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            max_speed_reg   <= max_speed_next;
            gain_reg        <= gain_next;
            min_pulse_reg   <= min_pulse_next;
            max_pulse_reg   <= max_pulse_next;
            max_angle_reg   <= max_angle_next;
            auto_detach_reg <= auto_detach_next;
            reverse_reg     <= reverse_next;
            enabled_reg     <= enabled_next;
            target_reg      <= target_next;
            stepped_reg     <= stepped_next;
            filtered_reg    <= filtered_next;
            attached_reg    <= attached_next;
            busy_reg        <= busy_next;
            pc_reg          <= pc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Datapath and result payload need no reset.
    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        val_reg          <= val_next;
        pulse_work_reg   <= pulse_work_next;
        written_work_reg <= written_work_next;
        arrived_work_reg <= arrived_work_next;
        prod_reg         <= prod_next;
        dq_reg           <= dq_next;
        rem_reg          <= rem_next;
        deg_neg_reg      <= deg_neg_next;
        div_cnt_reg      <= div_cnt_next;
        out_pulse_reg    <= out_pulse_next;
        out_written_reg  <= out_written_next;
        out_attached_reg <= out_attached_next;
        out_arrived_reg  <= out_arrived_next;
        out_position_reg <= out_position_next;
        out_target_reg   <= out_target_next;
    end

    assign out_valid      = out_valid_reg;
    assign pulse_width    = out_pulse_reg;
    assign pulse_written  = out_written_reg;
    assign drive_attached = out_attached_reg;
    assign arrived        = out_arrived_reg;
    assign position       = out_position_reg;
    assign target         = out_target_reg;

    // A result appears only from the finishing step of the program.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && pc_reg == ssm_pkg::L_FIN))
        else $error("result valid raised outside the finishing step");

    // An accepted request always starts at the dispatch step.
    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg && pc_reg == ssm_pkg::L_DISPATCH)
        else $error("accepted request did not start the program");

    // The divider never runs out of count while it is iterating.
    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && pc_reg == ssm_pkg::L_DIV) |-> div_cnt_reg != '0)
        else $error("divider stepped with an exhausted count");

    // The step counter stays inside the program.
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= ssm_pkg::L_FIN)
        else $error("step counter left the program");

endmodule
